/* design/fit_pkg.sv */
// ---------------------------------------------------------------------------
// fit_pkg: shared types and constants of the free interval table
// Table sizing, operation and status codes, controller states and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
package fit_pkg;

   localparam int unsigned TableDepth = 32;
   localparam int unsigned IdxW       = $clog2(TableDepth);
   localparam int unsigned CntW       = $clog2(TableDepth + 1);
   localparam int unsigned MemDepth   = 2 * (2 ** IdxW);
   localparam int unsigned CoordW     = 32;
   localparam int unsigned TotW       = CoordW + 1;

   typedef enum logic [1:0] {
      OP_RELEASE = 2'd0,
      OP_RESERVE = 2'd1,
      OP_FIND    = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_FULL     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_BEFORE = 2'd0,
      PH_MERGE  = 2'd1,
      PH_AFTER  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_PROC,
      S_EMIT2,
      S_FLUSH,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic rd;
      logic proc;
      logic emit2;
      logic flush;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic stop;
      logic at_end;
      logic want2;
   } sts_type;

endpackage

/* design/fit_if.sv */
// ---------------------------------------------------------------------------
// fit_req_if / fit_rsp_if: valid/ready channels of the free interval table
// Request words carry an operation and its span; response words the answer.
// ---------------------------------------------------------------------------
interface fit_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                op;
   logic [fit_pkg::CoordW-1:0] start_req;
   logic [fit_pkg::CoordW-1:0] end_req;
   logic [fit_pkg::CoordW-1:0] length;

   modport source (output valid, op, start_req, end_req, length, input ready);
   modport sink   (input valid, op, start_req, end_req, length, output ready);
endinterface

interface fit_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fit_pkg::CoordW-1:0] result_start;
   logic [fit_pkg::CoordW-1:0] result_end;
   logic                      found;
   logic [fit_pkg::TotW-1:0]   total_free;
   logic [1:0]                status;

   modport source (output valid, result_start, result_end, found, total_free, status,
                   input ready);
   modport sink   (input valid, result_start, result_end, found, total_free, status,
                   output ready);
endinterface

/* design/fit_dpath.sv */
// ---------------------------------------------------------------------------
// fit_dpath: interval table datapath
// Two table banks; each update streams the active bank into the other one,
// merging or cutting entries, and swaps banks only when the update commits.
// ---------------------------------------------------------------------------
module fit_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  fit_pkg::cmd_type            cmd,
   output fit_pkg::sts_type            sts,
   input  logic [1:0]                  req_op,
   input  logic [fit_pkg::CoordW-1:0]  req_start,
   input  logic [fit_pkg::CoordW-1:0]  req_end,
   input  logic [fit_pkg::CoordW-1:0]  req_len,
   output logic [fit_pkg::CoordW-1:0]  rsp_start,
   output logic [fit_pkg::CoordW-1:0]  rsp_end,
   output logic                        rsp_found,
   output logic [fit_pkg::TotW-1:0]    rsp_total,
   output logic [1:0]                  rsp_status
);

   localparam int unsigned CW = fit_pkg::CoordW;
   localparam int unsigned NW = fit_pkg::CntW;
   localparam int unsigned XW = fit_pkg::IdxW;
   localparam int unsigned TW = fit_pkg::TotW;

   // table banks
   logic [CW-1:0] mem_s [0:fit_pkg::MemDepth-1];
   logic [CW-1:0] mem_e [0:fit_pkg::MemDepth-1];
   logic [CW-1:0] rd_s_ff, rd_e_ff;

   logic              bank_ff, bank_in;
   logic [NW-1:0]     count_ff, count_in;
   logic [TW-1:0]     total_ff, total_in;
   fit_pkg::op_type   op_ff, op_in;
   logic [CW-1:0]     s_ff, s_in, e_ff, e_in, len_ff, len_in;
   logic [NW-1:0]     k_ff, k_in, wp_ff, wp_in;
   fit_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]     ms_ff, ms_in, me_ff, me_in;
   logic [TW-1:0]     removed_ff, removed_in;
   logic              any_ff, any_in, stop_ff, stop_in, inv_ff, inv_in;
   logic              full_ff, full_in, found_ff, found_in;
   logic [CW-1:0]     fs_ff, fs_in, fe_ff, fe_in;
   logic              e2v_ff, e2v_in;
   logic [CW-1:0]     e2s_ff, e2s_in, e2e_ff, e2e_in;
   logic [CW-1:0]     rs_ff, re_ff;
   logic              rf_ff;
   logic [TW-1:0]     rt_ff;
   fit_pkg::status_type rst_ff, rst_in;

   logic              ev, wr_en, commit;
   logic [CW-1:0]     es, ee, a, b, lo, hi, as_v;
   logic [XW:0]       rd_addr, wr_addr;

   assign a       = rd_s_ff;
   assign b       = rd_e_ff;
   assign rd_addr = {bank_ff, k_ff[XW-1:0]};
   assign wr_addr = {~bank_ff, wp_ff[XW-1:0]};
   assign lo      = (a > s_ff) ? a : s_ff;
   assign hi      = (b < e_ff) ? b : e_ff;
   assign as_v    = lo;

   // scan, merge, cut and emit
   always_comb begin
      op_in = op_ff; s_in = s_ff; e_in = e_ff; len_in = len_ff;
      k_in = k_ff; wp_in = wp_ff; phase_in = phase_ff;
      ms_in = ms_ff; me_in = me_ff; removed_in = removed_ff;
      any_in = any_ff; stop_in = stop_ff; inv_in = inv_ff; full_in = full_ff;
      found_in = found_ff; fs_in = fs_ff; fe_in = fe_ff;
      e2v_in = e2v_ff; e2s_in = e2s_ff; e2e_in = e2e_ff;
      ev = 1'b0; es = '0; ee = '0; wr_en = 1'b0;
      bank_in = bank_ff; count_in = count_ff; total_in = total_ff;
      commit = 1'b0; rst_in = fit_pkg::ST_OK;

      if (cmd.load) begin
         op_in = fit_pkg::op_type'(req_op);
         s_in = req_start; e_in = req_end; len_in = req_len;
         k_in = '0; wp_in = '0; phase_in = fit_pkg::PH_BEFORE;
         ms_in = req_start; me_in = req_end; removed_in = '0;
         any_in = 1'b0; full_in = 1'b0; found_in = 1'b0;
         fs_in = '0; fe_in = '0; e2v_in = 1'b0;
         case (fit_pkg::op_type'(req_op))
            fit_pkg::OP_RELEASE, fit_pkg::OP_RESERVE: inv_in = (req_start >= req_end);
            fit_pkg::OP_FIND:                         inv_in = (req_len == '0);
            default:                                  inv_in = 1'b1;
         endcase
         stop_in = inv_in;
      end

      if (cmd.rd) begin
         k_in = k_ff + NW'(1);
      end

      if (cmd.proc) begin
         e2v_in = 1'b0;
         case (op_ff)
            fit_pkg::OP_RELEASE: begin
               if (phase_ff == fit_pkg::PH_AFTER) begin
                  ev = 1'b1; es = a; ee = b;
               end else if (phase_ff == fit_pkg::PH_BEFORE && b < s_ff) begin
                  ev = 1'b1; es = a; ee = b;
               end else if (phase_ff == fit_pkg::PH_BEFORE && a <= s_ff && e_ff <= b) begin
                  // already free: leave table alone
                  stop_in = 1'b1;
               end else if (a <= me_ff) begin
                  phase_in   = fit_pkg::PH_MERGE;
                  ms_in      = (a < ms_ff) ? a : ms_ff;
                  me_in      = (b > me_ff) ? b : me_ff;
                  removed_in = removed_ff + TW'(b - a);
               end else begin
                  phase_in = fit_pkg::PH_AFTER;
                  ev = 1'b1; es = ms_ff; ee = me_ff;
                  e2v_in = 1'b1; e2s_in = a; e2e_in = b;
               end
            end
            fit_pkg::OP_RESERVE: begin
               if (b <= s_ff || a >= e_ff) begin
                  ev = 1'b1; es = a; ee = b;
               end else begin
                  any_in     = 1'b1;
                  removed_in = removed_ff + TW'(hi - lo);
                  if (a < s_ff) begin
                     ev = 1'b1; es = a; ee = s_ff;
                     if (b > e_ff) begin
                        e2v_in = 1'b1; e2s_in = e_ff; e2e_in = b;
                     end
                  end else if (b > e_ff) begin
                     ev = 1'b1; es = e_ff; ee = b;
                  end
               end
            end
            fit_pkg::OP_FIND: begin
               if (as_v < b && (b - as_v) >= len_ff) begin
                  found_in = 1'b1;
                  stop_in  = 1'b1;
                  fs_in    = as_v;
                  fe_in    = as_v + len_ff;
               end
            end
            default: begin
               stop_in = 1'b1;
            end
         endcase
      end

      if (cmd.emit2) begin
         ev = e2v_ff && !stop_ff; es = e2s_ff; ee = e2e_ff;
      end

      if (cmd.flush) begin
         ev = (op_ff == fit_pkg::OP_RELEASE) && (phase_ff != fit_pkg::PH_AFTER) && !stop_ff;
         es = ms_ff; ee = me_ff;
      end

      // write into the spare bank, or flag a full table
      if (ev) begin
         if (wp_ff == NW'(fit_pkg::TableDepth)) begin
            full_in = 1'b1;
            stop_in = 1'b1;
         end else begin
            wr_en = 1'b1;
            wp_in = wp_ff + NW'(1);
         end
      end

      // finish: commit (swap banks, update the free total) and pick the status
      if (cmd.finish) begin
         commit = !stop_ff && ((op_ff == fit_pkg::OP_RELEASE) ||
                               (op_ff == fit_pkg::OP_RESERVE && any_ff));
         if (commit) begin
            bank_in  = ~bank_ff;
            count_in = wp_ff;
            if (op_ff == fit_pkg::OP_RELEASE) begin
               total_in = total_ff - removed_ff + TW'(me_ff - ms_ff);
            end else begin
               total_in = total_ff - removed_ff;
            end
         end
         if (inv_ff) begin
            rst_in = fit_pkg::ST_INVALID;
         end else if (full_ff) begin
            rst_in = fit_pkg::ST_FULL;
         end else begin
            rst_in = fit_pkg::ST_OK;
         end
      end
   end

   assign sts.stop   = stop_ff;
   assign sts.at_end = (k_ff == count_ff);
   assign sts.want2  = e2v_in && cmd.proc;

   // table storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_s[wr_addr] <= es;
         mem_e[wr_addr] <= ee;
      end
      if (cmd.rd) begin
         rd_s_ff <= mem_s[rd_addr];
         rd_e_ff <= mem_e[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
         total_ff <= '0;
         stop_ff  <= 1'b0;
      end else begin
         bank_ff  <= bank_in;
         count_ff <= count_in;
         total_ff <= total_in;
         stop_ff  <= stop_in;
      end
   end

   // operation payload
   always_ff @(posedge clock) begin
      op_ff <= op_in; s_ff <= s_in; e_ff <= e_in; len_ff <= len_in;
      k_ff <= k_in; wp_ff <= wp_in; phase_ff <= phase_in;
      ms_ff <= ms_in; me_ff <= me_in; removed_ff <= removed_in;
      any_ff <= any_in; inv_ff <= inv_in; full_ff <= full_in;
      found_ff <= found_in; fs_ff <= fs_in; fe_ff <= fe_in;
      e2v_ff <= e2v_in; e2s_ff <= e2s_in; e2e_ff <= e2e_in;
      if (cmd.finish) begin
         rs_ff  <= fs_ff;
         re_ff  <= fe_ff;
         rf_ff  <= found_ff;
         rt_ff  <= total_in;
         rst_ff <= rst_in;
      end
   end

   assign rsp_start  = rs_ff;
   assign rsp_end    = re_ff;
   assign rsp_found  = rf_ff;
   assign rsp_total  = rt_ff;
   assign rsp_status = rst_ff;

endmodule

/* design/fit_ctrl.sv */
// ---------------------------------------------------------------------------
// fit_ctrl: interval table sequencer
// Steps the datapath through one table scan per word and owns the
// request ready and the response valid.
// ---------------------------------------------------------------------------
module fit_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  fit_pkg::sts_type  sts,
   output fit_pkg::cmd_type  cmd
);

   fit_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fit_pkg::S_IDLE:   if (req_valid) state_in = fit_pkg::S_READ;
         fit_pkg::S_READ: begin
            if (sts.stop) begin
               state_in = fit_pkg::S_FINISH;
            end else if (sts.at_end) begin
               state_in = fit_pkg::S_FLUSH;
            end else begin
               state_in = fit_pkg::S_PROC;
            end
         end
         fit_pkg::S_PROC:   state_in = sts.want2 ? fit_pkg::S_EMIT2 : fit_pkg::S_READ;
         fit_pkg::S_EMIT2:  state_in = fit_pkg::S_READ;
         fit_pkg::S_FLUSH:  state_in = fit_pkg::S_FINISH;
         fit_pkg::S_FINISH: if (out_free) state_in = fit_pkg::S_IDLE;
         default:           state_in = fit_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fit_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         fit_pkg::S_READ:   cmd.rd     = !sts.stop && !sts.at_end;
         fit_pkg::S_PROC:   cmd.proc   = 1'b1;
         fit_pkg::S_EMIT2:  cmd.emit2  = 1'b1;
         fit_pkg::S_FLUSH:  cmd.flush  = 1'b1;
         fit_pkg::S_FINISH: cmd.finish = out_free;
         default:           cmd        = '0;
      endcase
   end

   // hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fit_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/free_interval_table_core.sv */
// ---------------------------------------------------------------------------
// free_interval_table_core: sorted free interval table
// Releases, reserves and searches half-open spans, keeping a free total.
//
//   channel   | dir | word
//   ----------+-----+-----------------------------------------------------
//   req_chan  | in  | op, start_req, end_req, length
//   rsp_chan  | out | result_start, result_end, found, total_free, status
//
// One word at a time: the scan takes a read and a process step per table entry,
// and an emit step more when an entry leaves two pieces or a release closes its
// merged span; the single-port table read in the scan loop sets this. A find
// stops at its first fit and an invalid word skips the scan. Reset is
// synchronous and empties the table.
// A new request is taken while the previous response waits; the next one holds.
// ---------------------------------------------------------------------------
module free_interval_table_core (
   input  logic      clock,
   input  logic      reset,
   fit_req_if.sink   req_chan,
   fit_rsp_if.source rsp_chan
);

   fit_pkg::cmd_type cmd;
   fit_pkg::sts_type sts;

   fit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fit_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_op     (req_chan.op),
      .req_start  (req_chan.start_req),
      .req_end    (req_chan.end_req),
      .req_len    (req_chan.length),
      .rsp_start  (rsp_chan.result_start),
      .rsp_end    (rsp_chan.result_end),
      .rsp_found  (rsp_chan.found),
      .rsp_total  (rsp_chan.total_free),
      .rsp_status (rsp_chan.status)
   );

endmodule

/* test/free_interval_table_core_test.sv */
// ---------------------------------------------------------------------------
// free_interval_table_core_test: self-checking bench of the interval table
// Drives release, reserve and find words through the request channel, keeps
// a behavioral copy of the free table, predicts every response word and
// compares it field by field under several idle and stall mixes.
// ---------------------------------------------------------------------------
module free_interval_table_core_test;
   import fit_pkg::*;

   typedef struct {
      logic [CoordW-1:0] rstart;
      logic [CoordW-1:0] rend;
      logic              found;
      logic [TotW-1:0]   total;
      status_type        status;
   } answer_type;

   logic clock;
   logic reset;
   fit_req_if req_chan ();
   fit_rsp_if rsp_chan ();

   free_interval_table_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the free table
   logic [CoordW:0]   span_lo [TableDepth];
   logic [CoordW:0]   span_hi [TableDepth];
   int                span_num;
   logic [TotW-1:0]   free_sum;
   answer_type        pending_answers [$];
   int                errors;
   int                send_idle_pct;
   int                recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // replace entries [lo, hi) with n new entries
   task automatic splice_spans(input int lo, input int hi, input int n,
                               input logic [CoordW:0] ns [2],
                               input logic [CoordW:0] ne [2]);
      logic [CoordW:0] ts [TableDepth];
      logic [CoordW:0] te [TableDepth];
      int              k;
      int              m;
      m = 0;
      for (k = 0; k < lo; k++) begin
         ts[m] = span_lo[k]; te[m] = span_hi[k]; m++;
      end
      for (k = 0; k < n; k++) begin
         ts[m] = ns[k]; te[m] = ne[k]; m++;
      end
      for (k = hi; k < span_num; k++) begin
         ts[m] = span_lo[k]; te[m] = span_hi[k]; m++;
      end
      for (k = 0; k < m; k++) begin
         span_lo[k] = ts[k]; span_hi[k] = te[k];
      end
      span_num = m;
   endtask

   task automatic apply_release(input logic [CoordW:0] s, input logic [CoordW:0] e,
                                output status_type st);
      int              i;
      int              j;
      logic [CoordW:0] ms [2];
      logic [CoordW:0] me [2];
      logic [TotW:0]   removed;
      i = 0;
      removed = '0;
      ms[0] = s; me[0] = e; ms[1] = '0; me[1] = '0;
      st = ST_OK;
      if (s >= e) begin
         st = ST_INVALID;
         return;
      end
      while (i < span_num && span_hi[i] < s) i++;
      if (i < span_num && span_lo[i] <= s && e <= span_hi[i]) return;
      j = i;
      while (j < span_num && span_lo[j] <= me[0]) begin
         if (span_lo[j] < ms[0]) ms[0] = span_lo[j];
         if (span_hi[j] > me[0]) me[0] = span_hi[j];
         removed += span_hi[j] - span_lo[j];
         j++;
      end
      if (j == i && span_num >= TableDepth) begin
         st = ST_FULL;
         return;
      end
      splice_spans(i, j, 1, ms, me);
      free_sum = free_sum - removed + (me[0] - ms[0]);
   endtask

   task automatic apply_reserve(input logic [CoordW:0] s, input logic [CoordW:0] e,
                                output status_type st);
      int              i;
      int              j;
      int              k;
      int              n;
      logic [CoordW:0] ns [2];
      logic [CoordW:0] ne [2];
      logic [CoordW:0] os;
      logic [CoordW:0] oe;
      logic [TotW:0]   removed;
      i = 0;
      n = 0;
      removed = '0;
      ns[0] = '0; ns[1] = '0; ne[0] = '0; ne[1] = '0;
      st = ST_OK;
      if (s >= e) begin
         st = ST_INVALID;
         return;
      end
      while (i < span_num && span_hi[i] <= s) i++;
      j = i;
      while (j < span_num && span_lo[j] < e) j++;
      if (j == i) return;
      for (k = i; k < j; k++) begin
         os = (span_lo[k] > s) ? span_lo[k] : s;
         oe = (span_hi[k] < e) ? span_hi[k] : e;
         removed += oe - os;
      end
      if (span_lo[i] < s) begin
         ns[n] = span_lo[i]; ne[n] = s; n++;
      end
      if (span_hi[j-1] > e) begin
         ns[n] = e; ne[n] = span_hi[j-1]; n++;
      end
      if (n > j - i && span_num >= TableDepth) begin
         st = ST_FULL;
         return;
      end
      splice_spans(i, j, n, ns, ne);
      free_sum = free_sum - removed;
   endtask

   // compute the response word for one request word and update the table
   task automatic predict_table_answer(input op_type op, input logic [CoordW-1:0] s,
                                       input logic [CoordW-1:0] e,
                                       input logic [CoordW-1:0] len);
      answer_type      a;
      status_type      st;
      logic [CoordW:0] as;
      int              k;
      a.rstart = '0; a.rend = '0; a.found = 1'b0;
      st = ST_OK;
      case (op)
         OP_RELEASE: apply_release({1'b0, s}, {1'b0, e}, st);
         OP_RESERVE: apply_reserve({1'b0, s}, {1'b0, e}, st);
         OP_FIND: begin
            if (len == '0) begin
               st = ST_INVALID;
            end else begin
               for (k = 0; k < span_num; k++) begin
                  as = ({1'b0, s} > span_lo[k]) ? {1'b0, s} : span_lo[k];
                  if (as < span_hi[k] && span_hi[k] - as >= {1'b0, len}) begin
                     a.rstart = as[CoordW-1:0];
                     a.rend = as[CoordW-1:0] + len;
                     a.found = 1'b1;
                     break;
                  end
               end
            end
         end
         default: st = ST_INVALID;
      endcase
      a.total = free_sum;
      a.status = st;
      pending_answers.push_back(a);
   endtask

   // send one request word, idling at random first; valid stays high when
   // the next word follows with no gap
   task automatic send_word(input op_type op, input logic [CoordW-1:0] s,
                            input logic [CoordW-1:0] e, input logic [CoordW-1:0] len);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.start_req <= s;
      req_chan.end_req   <= e;
      req_chan.length    <= len;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_table_answer(op, s, e, len);
   endtask

   // random stall on the response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each accepted response word with the oldest expectation
   always @(posedge clock) begin
      answer_type x;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_answers.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
         end else begin
            x = pending_answers.pop_front();
            if (rsp_chan.result_start !== x.rstart) begin
               $error("result_start exp %h got %h", x.rstart, rsp_chan.result_start);
               errors++;
            end
            if (rsp_chan.result_end !== x.rend) begin
               $error("result_end exp %h got %h", x.rend, rsp_chan.result_end);
               errors++;
            end
            if (rsp_chan.found !== x.found) begin
               $error("found exp %b got %b", x.found, rsp_chan.found);
               errors++;
            end
            if (rsp_chan.total_free !== x.total) begin
               $error("total_free exp %h got %h", x.total, rsp_chan.total_free);
               errors++;
            end
            if (rsp_chan.status !== x.status) begin
               $error("status exp %0d got %0d", x.status, rsp_chan.status);
               errors++;
            end
         end
      end
   end

   function automatic logic [CoordW-1:0] rand_coord();
      case ($urandom_range(3))
         0: rand_coord = $urandom_range(255);
         1: rand_coord = $urandom_range(4095);
         2: rand_coord = 32'hFFFF_FF00 + $urandom_range(255);
         default: rand_coord = $urandom;
      endcase
   endfunction

   // drop valid and wait for every response
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_word(OP_FIND, 32'd0, 32'd0, 32'd1);
      send_word(OP_RESERVE, 32'd0, 32'd10, 32'd0);
      send_word(OP_RELEASE, 32'd10, 32'd10, 32'd0);
      send_word(OP_RELEASE, 32'd20, 32'd10, 32'd0);
      send_word(OP_RELEASE, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_FIND, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_word(OP_FIND, 32'd0, 32'd0, 32'd0);
      send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_RELEASE, 32'd5, 32'd100, 32'd0);
      send_word(OP_RESERVE, 32'd100, 32'd200, 32'd0);
      send_word(OP_RESERVE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0);
      send_word(OP_RESERVE, 32'd0, 32'hFFFF_FFFF, 32'd0);
      send_word(OP_RESERVE, 32'd0, 32'd1, 32'd0);
      send_word(OP_RELEASE, 32'd10, 32'd20, 32'd0);
      send_word(OP_RELEASE, 32'd30, 32'd40, 32'd0);
      send_word(OP_RELEASE, 32'd20, 32'd30, 32'd0);
      send_word(OP_FIND, 32'd15, 32'd0, 32'd20);
      send_word(OP_FIND, 32'd15, 32'd0, 32'd26);
      send_word(OP_RESERVE, 32'd5, 32'd45, 32'd0);
      send_word(OP_RESERVE, 32'd20, 32'd25, 32'd0);
      send_word(OP_FIND, 32'hFFFF_FFFF, 32'd0, 32'd1);
   endtask

   // fill the table with spans and gaps of width 2, then hit the full cases
   task automatic test_table_full();
      int k;
      send_word(OP_RESERVE, 32'd0, 32'hFFFF_FFFF, 32'd0);
      for (k = 0; k < TableDepth; k++)
         send_word(OP_RELEASE, k * 4, k * 4 + 2, 32'd0);
      send_word(OP_RELEASE, 32'd1000, 32'd1001, 32'd0);
      send_word(OP_RESERVE, 32'd4, 32'd5, 32'd0);
      send_word(OP_RELEASE, 32'd2, 32'd4, 32'd0);
      send_word(OP_RESERVE, 32'd4, 32'd5, 32'd0);
      send_word(OP_FIND, 32'd3, 32'd0, 32'd2);
   endtask

   task automatic test_random(input int count);
      int            k;
      int            r;
      logic [CoordW-1:0] s;
      logic [CoordW-1:0] e;
      for (k = 0; k < count; k++) begin
         s = rand_coord();
         r = $urandom_range(99);
         if (r < 6) e = rand_coord();
         else e = s + $urandom_range(1, (r < 50) ? 64 : 2000);
         r = $urandom_range(99);
         if (r < 42) send_word(OP_RELEASE, s, e, $urandom);
         else if (r < 72) send_word(OP_RESERVE, s, e, $urandom);
         else if (r < 97) send_word(OP_FIND, s, $urandom,
                                    ($urandom_range(9) == 0) ? $urandom : $urandom_range(300));
         else send_word(OP_UNUSED, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      errors = 0;
      span_num = 0;
      free_sum = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = OP_RELEASE;
      req_chan.start_req = '0;
      req_chan.end_req = '0;
      req_chan.length = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      send_word(OP_RESERVE, 32'd0, 32'hFFFF_FFFF, 32'd0);
      send_word(OP_RELEASE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0);
      test_random(100);
      send_idle_pct = 72;
      test_random(100);
      send_idle_pct = 0;
      recv_stall_pct = 72;
      test_random(100);
      send_idle_pct = 38;
      recv_stall_pct = 38;
      test_random(100);
      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
